// File: hw/rtl/bfra_pkg.sv
// Package for the best-fit region allocator: sizes, codes and cell types.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps
package bfra_pkg;
   localparam int MaxFreeBlocks = 16;
   localparam int AddrBits      = 48;
   localparam int FieldBits     = 48;
   localparam int IdxBits       = $clog2(MaxFreeBlocks);
   localparam int CntBits       = $clog2(MaxFreeBlocks + 1);

   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [IdxBits-1:0]  idx_type;
   typedef logic [CntBits-1:0]  cnt_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_NOFIT   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   localparam logic CsrBase   = 1'b0;
   localparam logic CsrLength = 1'b1;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SET,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP
   } cell_op_type;

   // Command broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      cell_op_type op;
      idx_type     index;
      idx_type     limit;
      addr_type    start;
      addr_type    len;
   } cell_cmd_type;

   typedef struct packed {
      addr_type start;
      addr_type len;
   } entry_type;
endpackage

// File: hw/rtl/bfra_cell.sv
// One cell of the free-block chain: holds one entry and moves it to or from
// its neighbors on a shift command. Depends on bfra_pkg.
`timescale 1ns / 1ps
module bfra_cell (
   input  logic                  clock,
   input  bfra_pkg::idx_type     my_index,
   input  bfra_pkg::cell_cmd_type cmd,
   input  bfra_pkg::entry_type   from_lower,
   input  bfra_pkg::entry_type   from_upper,
   output bfra_pkg::entry_type   entry
);
   import bfra_pkg::*;
   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_LOAD: begin
            entry_in.start = (my_index == '0) ? cmd.start : '0;
            entry_in.len   = (my_index == '0) ? cmd.len : '0;
         end
         CELL_SET: begin
            if (my_index == cmd.index) begin
               entry_in.start = cmd.start;
               entry_in.len   = cmd.len;
            end
         end
         CELL_SHIFT_DOWN: begin
            if (my_index >= cmd.index && my_index < cmd.limit) begin
               entry_in = from_upper;
            end else if (my_index == cmd.limit) begin
               entry_in = '0;
            end
         end
         CELL_SHIFT_UP: begin
            if (my_index > cmd.index && my_index <= cmd.limit) begin
               entry_in = from_lower;
            end else if (my_index == cmd.index) begin
               entry_in.start = cmd.start;
               entry_in.len   = cmd.len;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule

// File: hw/rtl/bfra_chain.sv
// Row of cells that holds the free-block table sorted by address.
// Depends on bfra_pkg and bfra_cell.
`timescale 1ns / 1ps
module bfra_chain (
   input  logic                   clock,
   input  bfra_pkg::cell_cmd_type cmd,
   input  bfra_pkg::idx_type      rd_index,
   input  bfra_pkg::idx_type      prev_index,
   output bfra_pkg::entry_type    rd_entry,
   output bfra_pkg::entry_type    rd_prev
);
   import bfra_pkg::*;
   entry_type entries [MaxFreeBlocks];

   for (genvar g = 0; g < MaxFreeBlocks; g++) begin : g_cell
      entry_type lower, upper;
      if (g == 0) begin : g_lo
         assign lower = '0;
      end else begin : g_lo
         assign lower = entries[g-1];
      end
      if (g == MaxFreeBlocks - 1) begin : g_up
         assign upper = '0;
      end else begin : g_up
         assign upper = entries[g+1];
      end
      bfra_cell u_cell (
         .clock      (clock),
         .my_index   (idx_type'(g)),
         .cmd        (cmd),
         .from_lower (lower),
         .from_upper (upper),
         .entry      (entries[g])
      );
   end

   assign rd_entry = entries[rd_index];
   assign rd_prev  = entries[prev_index];
endmodule

// File: hw/rtl/best_fit_region_allocator.sv
// Top level of the best-fit region allocator: sequencer over the cell chain.
// Depends on bfra_pkg, bfra_chain and bfra_cell.
`timescale 1ns / 1ps
// A request is one reserve or release on a table of up to 16 free blocks held
// in a chain of cells sorted by address. The sequencer scans the table, reading
// one entry a cycle; a reserve then shrinks or removes the best-fitting entry,
// or reports no fit, and a release joins one or both neighbors or inserts a
// new entry, or reports a full table. A zero-size request goes straight to
// the response with an invalid status. One request is in work at a time.
// The response waits in an output register while rsp_stall is high, and the
// next request can be accepted and worked on meanwhile. A csr write, once
// registered, reloads the table and must come only while the block is idle.
module best_fit_region_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [47:0]           req_size,
   input  logic [47:0]           req_release_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic [47:0]           rsp_granted_addr,
   output logic [47:0]           rsp_granted_offset,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [47:0]           csr_data
);
   import bfra_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_RESERVE, ST_REL_CHECK, ST_REL_MERGE, ST_RESP
   } state_type;

   state_type    state_ff;
   logic         mode_ff;
   addr_type     size_ff, rel_ff, base_ff, length_ff;
   cnt_type      count_ff, ins_ff;
   idx_type      scan_ff, best_ff;
   logic         found_ff, ins_found_ff;
   addr_type     best_len_ff;
   logic [1:0]   status_ff;
   addr_type     addr_ff, offset_ff;
   logic         rsp_valid_ff;
   logic         csr_pending_ff;
   addr_type     new_base, new_len;
   logic         fix3_ff;
   idx_type      fix3_idx_ff;
   addr_type     fix3_len_ff, fix3_start_ff;

   cell_cmd_type cmd;
   idx_type      rd_index, prev_index;
   entry_type    rd_entry, rd_prev;

   bfra_chain u_chain (
      .clock      (clock),
      .cmd        (cmd),
      .rd_index   (rd_index),
      .prev_index (prev_index),
      .rd_entry   (rd_entry),
      .rd_prev    (rd_prev)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign new_base   = (csr_write && csr_index == CsrBase) ? csr_data : base_ff;
   assign new_len    = (csr_write && csr_index == CsrLength) ? csr_data : length_ff;
   assign prev_index = idx_type'(ins_ff - cnt_type'(1));

   // In the merge state, ins_ff names the upper neighbor (or the count at end).
   addr_type prev_end, up_end;
   logic     has_up, has_prev;
   assign has_up   = ins_ff < count_ff && ins_found_ff;
   assign has_prev = ins_ff != '0 && count_ff != '0;
   assign prev_end = rd_prev.start + rd_prev.len;
   assign up_end   = rel_ff + size_ff;

   always_comb begin
      cmd       = '0;
      cmd.op    = CELL_HOLD;
      rd_index  = scan_ff;
      if (state_ff == ST_RESERVE || state_ff == ST_REL_MERGE) begin
         rd_index = (state_ff == ST_RESERVE) ? best_ff : idx_type'(ins_ff);
      end
      if (csr_pending_ff) begin
         cmd.op    = CELL_LOAD;
         cmd.start = base_ff;
         cmd.len   = length_ff;
      end else if (fix3_ff) begin
         cmd.op    = CELL_SET;
         cmd.index = fix3_idx_ff;
         cmd.start = fix3_start_ff;
         cmd.len   = fix3_len_ff;
      end else if (state_ff == ST_RESERVE) begin
         cmd.index = best_ff;
         cmd.limit = idx_type'(count_ff - cnt_type'(1));
         if (rd_entry.len == size_ff) begin
            cmd.op = CELL_SHIFT_DOWN;
         end else begin
            cmd.op    = CELL_SET;
            cmd.start = rd_entry.start + size_ff;
            cmd.len   = rd_entry.len - size_ff;
         end
      end else if (state_ff == ST_REL_MERGE) begin
         if (has_up && rd_entry.start == up_end) begin
            if (has_prev && prev_end == rel_ff) begin
               cmd.op    = CELL_SHIFT_DOWN;
               cmd.index = prev_index;
               cmd.limit = idx_type'(count_ff - cnt_type'(1));
            end else begin
               cmd.op    = CELL_SET;
               cmd.index = idx_type'(ins_ff);
               cmd.start = rel_ff;
               cmd.len   = rd_entry.len + size_ff;
            end
         end else if (has_prev && prev_end == rel_ff) begin
            cmd.op    = CELL_SET;
            cmd.index = prev_index;
            cmd.start = rd_prev.start;
            cmd.len   = rd_prev.len + size_ff;
         end else if (count_ff < cnt_type'(MaxFreeBlocks)) begin
            cmd.op    = CELL_SHIFT_UP;
            cmd.index = idx_type'(ins_ff);
            cmd.limit = idx_type'(count_ff);
            cmd.start = rel_ff;
            cmd.len   = size_ff;
         end
      end
   end

   // A three-way merge shifts entries down from the lower neighbor; the
   // combined block is written into that entry on the following cycle.
   entry_type merged3;
   assign merged3.start = rd_prev.start;
   assign merged3.len   = rd_prev.len + rd_entry.len + size_ff;

   logic     three_way;
   assign three_way = state_ff == ST_REL_MERGE && cmd.op == CELL_SHIFT_DOWN;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         base_ff        <= 48'd1;
         length_ff      <= 48'd1;
         count_ff       <= cnt_type'(1);
         csr_pending_ff <= 1'b1;
         fix3_ff        <= 1'b0;
      end else begin
         fix3_ff <= three_way;
         if (csr_write) begin
            base_ff        <= new_base;
            length_ff      <= new_len;
            count_ff       <= (new_len != '0) ? cnt_type'(1) : '0;
            csr_pending_ff <= 1'b1;
         end else begin
            csr_pending_ff <= 1'b0;
         end
         if (state_ff == ST_RESP && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  mode_ff      <= req_mode;
                  size_ff      <= req_size;
                  rel_ff       <= req_release_addr;
                  scan_ff      <= '0;
                  found_ff     <= 1'b0;
                  ins_found_ff <= 1'b0;
                  ins_ff       <= '0;
                  addr_ff      <= '0;
                  offset_ff    <= '0;
                  if (req_size == '0) begin
                     status_ff <= STATUS_INVALID;
                     state_ff  <= ST_RESP;
                  end else begin
                     status_ff <= STATUS_OK;
                     state_ff  <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if ({1'b0, scan_ff} >= count_ff) begin
                  if (!mode_ff) begin
                     if (found_ff) begin
                        state_ff <= ST_RESERVE;
                     end else begin
                        status_ff <= STATUS_NOFIT;
                        state_ff  <= ST_RESP;
                     end
                  end else begin
                     if (!ins_found_ff) begin
                        ins_ff <= count_ff;
                     end
                     state_ff <= ST_REL_MERGE;
                  end
               end else begin
                  if (!mode_ff) begin
                     if (rd_entry.len >= size_ff &&
                         (!found_ff || rd_entry.len < best_len_ff)) begin
                        best_ff     <= scan_ff;
                        best_len_ff <= rd_entry.len;
                        found_ff    <= 1'b1;
                     end
                  end else if (!ins_found_ff && rel_ff < rd_entry.start) begin
                     ins_ff       <= {1'b0, scan_ff};
                     ins_found_ff <= 1'b1;
                  end
                  if (scan_ff == idx_type'(MaxFreeBlocks - 1)) begin
                     // Table end: hold the index and make the exit decision here.
                     scan_ff <= scan_ff;
                     if (!mode_ff) begin
                        if (rd_entry.len >= size_ff &&
                            (!found_ff || rd_entry.len < best_len_ff)) begin
                           state_ff <= ST_RESERVE;
                        end else begin
                           state_ff <= found_ff ? ST_RESERVE : ST_RESP;
                           if (!found_ff) status_ff <= STATUS_NOFIT;
                        end
                     end else begin
                        if (!ins_found_ff && !(rel_ff < rd_entry.start)) begin
                           ins_found_ff <= 1'b0;
                           ins_ff       <= count_ff;
                        end
                        state_ff <= ST_REL_MERGE;
                     end
                  end else begin
                     scan_ff <= scan_ff + idx_type'(1);
                  end
               end
            end
            ST_RESERVE: begin
               addr_ff   <= rd_entry.start;
               offset_ff <= rd_entry.start - base_ff;
               if (rd_entry.len == size_ff) begin
                  count_ff <= count_ff - cnt_type'(1);
               end
               state_ff <= ST_RESP;
            end
            ST_REL_MERGE: begin
               if (three_way) begin
                  count_ff      <= count_ff - cnt_type'(1);
                  fix3_idx_ff   <= prev_index;
                  fix3_start_ff <= merged3.start;
                  fix3_len_ff   <= merged3.len;
                  state_ff      <= ST_REL_CHECK;
               end else begin
                  if (cmd.op == CELL_SHIFT_UP) begin
                     count_ff <= count_ff + cnt_type'(1);
                  end else if (cmd.op == CELL_HOLD) begin
                     status_ff <= STATUS_FULL;
                  end
                  state_ff <= ST_RESP;
               end
            end
            ST_REL_CHECK: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff == 1'b0 || !rsp_stall) begin
         if (state_ff == ST_RESP) begin
            rsp_status         <= status_ff;
            rsp_granted_addr   <= addr_ff;
            rsp_granted_offset <= offset_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != ST_IDLE) |-> req_stall;
   endproperty
   assert property (p_no_accept_busy) else $error("request accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(MaxFreeBlocks))
      else $error("free count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");
endmodule
